[design/mp2_pkg.sv]
// Package with shared types, constants and the float compare for the 2x2 max pool.
`timescale 1ns / 1ps
`default_nettype none
package mp2_pkg;
  localparam int MaxRow = 1024;
  localparam int ColW = $clog2(MaxRow);
  localparam int WidthW = 11;
  localparam logic [WidthW-1:0] WidthReset = WidthW'(MaxRow);

  typedef struct packed {
    logic        window;
    logic        last;
    logic [ColW-1:0] col;
    logic [31:0] prior;
    logic [31:0] pixel;
  } mp2_job_t;

  // True when a > b under the IEEE ordered compare.
  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic res;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan || (a_zero && b_zero)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = b[31];
    end else if (a[31] == 1'b0) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction
endpackage
`default_nettype wire

[design/mp2_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module mp2_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[design/mp2_front.sv]
// Front end: accepts pixels, tracks column and row parity, writes the line buffer.
`timescale 1ns / 1ps
`default_nettype none
module mp2_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [mp2_pkg::WidthW-1:0]    row_width,
  input  wire logic                          acc,
  input  wire logic [31:0]                   pixel,
  input  wire logic                          last,
  output logic                               we,
  output logic [mp2_pkg::ColW-1:0]           waddr,
  output mp2_pkg::mp2_job_t                  job
);
  import mp2_pkg::*;
  logic [ColW-1:0] col_r, col_nxt;
  logic odd_r, odd_nxt;
  logic [31:0] prior_r;
  logic [WidthW-1:0] w_eff;
  logic [WidthW-1:0] col_ext;

  always_comb begin
    if (row_width < WidthW'(2)) begin
      w_eff = WidthW'(2);
    end else if (row_width > WidthW'(MaxRow)) begin
      w_eff = WidthW'(MaxRow);
    end else begin
      w_eff = row_width;
    end
    col_ext = WidthW'(col_r);
    odd_nxt = odd_r;
    if (col_ext >= w_eff - WidthW'(1)) begin
      col_nxt = '0;
      odd_nxt = ~odd_r;
    end else begin
      col_nxt = col_r + ColW'(1);
    end
    if (last) begin
      col_nxt = '0;
      odd_nxt = 1'b0;
    end
  end

  assign we = acc && !odd_r;
  assign waddr = col_r;
  assign job.window = acc && odd_r && col_r[0];
  assign job.last = last;
  assign job.col = col_r;
  assign job.prior = prior_r;
  assign job.pixel = pixel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
      prior_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
      prior_r <= pixel;
    end
  end
endmodule
`default_nettype wire

[design/mp2_back.sv]
// Back end: reads the stored row pair, compares the window and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module mp2_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  input  mp2_pkg::mp2_job_t job_in,
  input  wire logic [31:0] up_left,
  input  wire logic [31:0] up_right,
  output logic             stage_valid,
  output logic [32:0]      res,
  output logic             res_valid,
  input  wire logic        res_ready
);
  import mp2_pkg::*;
  logic s1_valid_r;
  mp2_job_t s1_r;
  logic [31:0] m1, m2, best;
  logic s1_move;

  assign stage_valid = s1_valid_r;
  assign s1_move = s1_valid_r && (!res_valid || res_ready);

  always_comb begin
    m1 = fp_gt(up_right, up_left) ? up_right : up_left;
    m2 = fp_gt(s1_r.prior, m1) ? s1_r.prior : m1;
    best = fp_gt(s1_r.pixel, m2) ? s1_r.pixel : m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (job_valid) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      s1_r <= job_in;
    end
    if (s1_move) begin
      res <= {s1_r.last, best};
    end
  end
endmodule
`default_nettype wire

[design/maxpool_2x2_stride2_stream.sv]
// Top level of the streaming 2x2 stride-2 float max pool.
// Usage: pixels (IEEE single) enter on the in_ stream in raster order, one
// per transaction; in_tlast marks the last pixel of a plane. cfg_we with
// cfg_wdata sets the row width (2..1024, clamped); the user must write it
// only while the block is idle, which the block does not enforce. On odd
// rows at odd columns one result leaves on the out_ stream with the window
// maximum; out_tlast is set when its pixel closed the plane. Throughput is
// one pixel per cycle while the receiver keeps up. A window is read from
// the line buffer, then compared into the output register. A pixel of any
// kind is accepted only when the compare stage is free or moving, so a
// stalled receiver stops all input once two results are queued, one in the
// compare stage and one in the output register. Writes and reads of the
// line buffer fall on different rows, so they never collide.
// Reset clears the column, parity, previous pixel and all valid flags and
// sets the row width to 1024; the line buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module maxpool_2x2_stride2_stream (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // pixel_bits
  input  wire logic        in_tlast,   // plane_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // max_bits
  output logic             out_tlast   // plane_done
);
  import mp2_pkg::*;
  logic [WidthW-1:0] width_r;
  logic acc, we, stage_valid;
  logic [ColW-1:0] waddr;
  mp2_job_t job;
  logic [31:0] up_l, up_r;
  logic [32:0] res;
  logic [ColW-1:0] ra_l;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WidthReset;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  assign in_tready = !stage_valid || !out_tvalid || out_tready;
  assign acc = in_tvalid && in_tready;
  assign ra_l = {job.col[ColW-1:1], 1'b0};

  mp2_front u_front (
    .clk(clk), .rst_n(rst_n), .row_width(width_r), .acc(acc),
    .pixel(in_tdata), .last(in_tlast), .we(we), .waddr(waddr), .job(job)
  );

  mp2_ram #(.Width(32), .Depth(MaxRow)) u_ram_l (
    .clk(clk), .we(we && !waddr[0]), .waddr(waddr), .wdata(in_tdata),
    .re(job.window), .raddr(ra_l), .rdata(up_l)
  );

  mp2_ram #(.Width(32), .Depth(MaxRow)) u_ram_r (
    .clk(clk), .we(we && waddr[0]), .waddr(waddr), .wdata(in_tdata),
    .re(job.window), .raddr(job.col), .rdata(up_r)
  );

  mp2_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job.window), .job_in(job),
    .up_left(up_l), .up_right(up_r), .stage_valid(stage_valid),
    .res(res), .res_valid(out_tvalid), .res_ready(out_tready)
  );

  assign out_tdata = res[31:0];
  assign out_tlast = res[32];
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the streaming 2x2 stride-2 float max pool.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import mp2_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [10:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;

  maxpool_2x2_stride2_stream dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } pool_result_t;

  typedef struct {
    logic [31:0] pixel;
    logic        last;
    logic        check_bits;
    logic [31:0] known_max;
  } pixel_row_t;

  localparam logic [31:0] PosOne  = 32'h3F80_0000;
  localparam logic [31:0] NegOne  = 32'hBF80_0000;
  localparam logic [31:0] PosInf  = 32'h7F80_0000;
  localparam logic [31:0] NegInf  = 32'hFF80_0000;
  localparam logic [31:0] QuietNan = 32'h7FC0_0000;
  localparam logic [31:0] NegZero = 32'h8000_0000;
  localparam logic [31:0] PosTwo  = 32'h4000_0000;
  localparam int CycleLimit = 2_000_000;
  localparam int ItemTarget = 1400;

  logic [31:0]  line_pixels [MaxRow];
  int unsigned  col_pos;
  logic         on_odd_row;
  logic [31:0]  left_pixel;
  int unsigned  width_reg;
  pool_result_t pending_max [$];
  int           mismatches;
  int           cycles;
  int           sender_gap;
  int           burst_left;
  int           stall_phase;
  int           sent_items;

  function automatic logic float_above(logic [31:0] a, logic [31:0] b);
    logic an;
    logic bn;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    if (an || bn) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    if (a[31] != b[31]) return b[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  task automatic predict_window(input logic [31:0] pix, input logic last);
    int unsigned w;
    int unsigned x;
    logic [31:0] best;
    logic [31:0] cand [4];
    pool_result_t r;
    w = width_reg < 2 ? 2 : (width_reg > MaxRow ? MaxRow : width_reg);
    x = col_pos >= MaxRow ? 0 : col_pos;
    if (!on_odd_row) begin
      line_pixels[x] = pix;
    end else if (x[0]) begin
      cand[0] = line_pixels[x-1];
      cand[1] = line_pixels[x];
      cand[2] = left_pixel;
      cand[3] = pix;
      best = cand[0];
      for (int p = 1; p < 4; p++) if (float_above(cand[p], best)) best = cand[p];
      r.bits = best;
      r.last = last;
      pending_max.push_back(r);
    end
    left_pixel = pix;
    if (x >= w - 1) begin
      col_pos = 0;
      on_odd_row = ~on_odd_row;
    end else begin
      col_pos = x + 1;
    end
    if (last) begin
      col_pos = 0;
      on_odd_row = 1'b0;
    end
  endtask

  task automatic send_pixel(input logic [31:0] pix, input logic last);
    if (burst_left == 0) begin
      sender_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
      if (sender_gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (sender_gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    sent_items++;
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_window(pix, last);
  endtask

  task automatic pause_until_empty();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_max.size() != 0) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_max.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_width(input int unsigned w);
    cfg_we <= 1'b1;
    cfg_wdata <= w[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w & 11'h7FF;
  endtask

  function automatic logic [31:0] random_pixel();
    case ($urandom_range(0, 9))
      0: return QuietNan | $urandom_range(0, 1) << 31 | $urandom_range(1, 32'h3F_FFFF);
      1: return $urandom_range(0, 1) ? PosInf : NegInf;
      2: return $urandom_range(0, 1) ? 32'h0 : NegZero;
      3: return {1'($urandom_range(0, 1)), 8'd127, 23'($urandom_range(0, 3))};
      default: return $urandom;
    endcase
  endfunction

  task automatic random_plane(input int unsigned w, input int unsigned rows);
    int unsigned total;
    total = w * rows;
    for (int unsigned i = 0; i < total; i++) begin
      send_pixel(random_pixel(), i == total - 1);
    end
  endtask

  // Directed windows at a row width of two.
  pixel_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    col_pos = 0;
    on_odd_row = 1'b0;
    left_pixel = '0;
    width_reg = MaxRow;
    mismatches = 0;
    burst_left = 0;
    sent_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_width(2);
    // Even row then odd row of width two: one window per pair of rows.
    directed_rows = '{
      '{PosOne, 1'b0, 1'b0, 32'h0}, '{NegOne, 1'b0, 1'b0, 32'h0},
      '{PosTwo, 1'b0, 1'b0, 32'h0}, '{NegInf, 1'b0, 1'b1, PosTwo},
      '{QuietNan, 1'b0, 1'b0, 32'h0}, '{PosInf, 1'b0, 1'b0, 32'h0},
      '{PosOne, 1'b0, 1'b0, 32'h0}, '{PosTwo, 1'b0, 1'b1, QuietNan},
      '{32'h0, 1'b0, 1'b0, 32'h0}, '{NegZero, 1'b0, 1'b0, 32'h0},
      '{NegZero, 1'b0, 1'b0, 32'h0}, '{32'h0, 1'b1, 1'b1, 32'h0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0}, '{32'h7F7F_FFFF, 1'b0, 1'b0, 32'h0},
      '{32'hFF7F_FFFF, 1'b0, 1'b0, 32'h0}, '{PosInf, 1'b0, 1'b1, 32'hFFFF_FFFF},
      '{PosOne, 1'b0, 1'b0, 32'h0}, '{PosOne, 1'b0, 1'b0, 32'h0},
      '{PosOne, 1'b1, 1'b0, 32'h0}, '{NegOne, 1'b0, 1'b0, 32'h0},
      '{PosOne, 1'b0, 1'b0, 32'h0}, '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{32'h8000_0001, 1'b1, 1'b1, PosOne}
    };
    foreach (directed_rows[i]) begin
      if (directed_rows[i].check_bits) begin
        send_pixel(directed_rows[i].pixel, directed_rows[i].last);
        if (pending_max.size() == 0 ||
            pending_max[$].bits != directed_rows[i].known_max) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %h got %h", i, directed_rows[i].known_max,
                     pending_max.size() == 0 ? 32'hx : pending_max[$].bits);
        end
      end else begin
        send_pixel(directed_rows[i].pixel, directed_rows[i].last);
      end
    end
    drain_and_settle();

    write_width(0);
    random_plane(2, 4);
    drain_and_settle();
    // Clamped width: one full row, then the first window of the next row.
    write_width(11'h7FF);
    for (int i = 0; i < MaxRow + 2; i++) begin
      send_pixel(random_pixel(), i == MaxRow + 1);
    end
    drain_and_settle();
    write_width(7);
    random_plane(7, 5);
    drain_and_settle();

    while (sent_items < ItemTarget) begin
      int unsigned w;
      drain_and_settle();
      w = $urandom_range(0, 4) == 0 ? $urandom_range(2, 40) : 2 * $urandom_range(1, 8);
      write_width(w);
      for (int k = 0; k < 12 && sent_items < ItemTarget; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_pixel(random_pixel(), 1'b1);
        else
          random_plane(w, 2 * $urandom_range(1, 3));
        if ($urandom_range(0, 5) == 0) begin
          pause_until_empty();
        end
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 23;
      out_tready <= stall_phase < 8 ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    pool_result_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_max.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", out_tdata);
      end else begin
        want = pending_max.pop_front();
        if (want.bits !== out_tdata || want.last !== out_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected %h/%b got %h/%b", want.bits, want.last, out_tdata, out_tlast);
        end
      end
    end
  end

  initial cycles = 0;
endmodule
`default_nettype wire

[filelist.f]
design/mp2_pkg.sv
design/mp2_ram.sv
design/mp2_front.sv
design/mp2_back.sv
design/maxpool_2x2_stride2_stream.sv
tb/testbench.sv
